### rtl/front_middle_back_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the front/middle/back queue
// Concurrent assertion wrappers that are removed in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FRONT_MIDDLE_BACK_QUEUE_ASSERT_SVH
`define FRONT_MIDDLE_BACK_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define FMBQ_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define FMBQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FMBQ_ASSERT(name, clk, rstn, prop, msg)
`define FMBQ_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### rtl/fmbq_pkg.sv
// ---------------------------------------------------------------------------
// fmbq_pkg
// Shared types and constants of the front/middle/back queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmbq_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int CMD_W       = 3;
  localparam int DATA_W      = 32;
  localparam int ST_W        = 2;
  localparam int OCC_W       = 11;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ISSUE,
    S_CAPTURE,
    S_MOVE,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic issue;
    logic capture;
    logic move;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic noop;
    logic pop;
    logic has_moves;
    logic last_move;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/fmbq_ram.sv
// ---------------------------------------------------------------------------
// fmbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/fmbq_dpath.sv
// ---------------------------------------------------------------------------
// fmbq_dpath
// Circular entry store, head and count registers, move engine and result
// register of the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmbq_dpath #(
  parameter int DEPTH = fmbq_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [fmbq_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire fmbq_pkg::ctl_t                      ctl,
  output fmbq_pkg::sts_t                           sts,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic      [fmbq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int DW = fmbq_pkg::DATA_W;
  localparam int PAD_W = fmbq_pkg::OUT_TDATA_W - fmbq_pkg::OCC_W - DW - fmbq_pkg::ST_W;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fmbq_pkg::cmd_t    cmd_r;
  logic [DW-1:0]     value_r;
  logic [AW-1:0]     head_r;
  logic [AW-1:0]     head_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [AW-1:0]     tgt_r;
  logic [CW-1:0]     left_r;
  logic [AW-1:0]     rd_ph_r;
  logic              wp_r;
  logic [AW-1:0]     wp_addr_r;
  logic              ins_r;
  fmbq_pkg::status_t st_r;
  logic              noop_r;
  logic [DW-1:0]     data_r;

  logic                      out_valid_r;
  logic [fmbq_pkg::ST_W-1:0] out_status_r;
  logic [DW-1:0]             out_data_r;
  logic [fmbq_pkg::OCC_W-1:0] out_occ_r;

  logic              is_push;
  logic              is_pop;
  fmbq_pkg::status_t dec_st;
  logic              dec_noop;
  logic [AW-1:0]     dec_tgt;
  logic [CW-1:0]     dec_moves;
  logic [CW-1:0]     half_up;
  logic [CW-1:0]     half_dn;
  logic [DW-1:0]     res_data;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  assign is_push = (cmd_r == fmbq_pkg::CMD_PUSH_FRONT) ||
                   (cmd_r == fmbq_pkg::CMD_PUSH_MIDDLE) ||
                   (cmd_r == fmbq_pkg::CMD_PUSH_BACK);
  assign is_pop  = (cmd_r == fmbq_pkg::CMD_POP_FRONT) ||
                   (cmd_r == fmbq_pkg::CMD_POP_MIDDLE) ||
                   (cmd_r == fmbq_pkg::CMD_POP_BACK);

  assign half_up = count_r >> 1;
  assign half_dn = (count_r - CW'(1)) >> 1;

  always_comb begin
    dec_st = fmbq_pkg::ST_OK;
    if (is_push && (count_r == CW'(DEPTH))) begin
      dec_st = fmbq_pkg::ST_FULL;
    end else if (is_pop && (count_r == '0)) begin
      dec_st = fmbq_pkg::ST_EMPTY;
    end
    dec_noop = !(is_push || is_pop) || (dec_st != fmbq_pkg::ST_OK);

    dec_tgt   = head_r;
    dec_moves = '0;
    case (cmd_r)
      fmbq_pkg::CMD_PUSH_FRONT: begin
        dec_tgt = wrap_dec(head_r);
      end
      fmbq_pkg::CMD_PUSH_MIDDLE: begin
        dec_tgt   = wrap_add(wrap_dec(head_r), half_up);
        dec_moves = half_up;
      end
      fmbq_pkg::CMD_PUSH_BACK: begin
        dec_tgt = wrap_add(head_r, count_r);
      end
      fmbq_pkg::CMD_POP_FRONT: begin
        dec_tgt = head_r;
      end
      fmbq_pkg::CMD_POP_MIDDLE: begin
        dec_tgt   = wrap_add(head_r, half_dn);
        dec_moves = half_dn;
      end
      fmbq_pkg::CMD_POP_BACK: begin
        dec_tgt = wrap_add(head_r, count_r - CW'(1));
      end
      default: begin
        dec_tgt = head_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= fmbq_pkg::cmd_t'(in_tdata[fmbq_pkg::CMD_W-1:0]);
      value_r <= in_tdata[fmbq_pkg::CMD_W +: DW];
    end
    if (ctl.decode) begin
      st_r   <= dec_st;
      noop_r <= dec_noop;
      tgt_r  <= dec_tgt;
      ins_r  <= (cmd_r == fmbq_pkg::CMD_PUSH_MIDDLE);
    end
    if (ctl.issue) begin
      rd_ph_r <= ins_r ? head_r : wrap_dec(tgt_r);
    end else if (ctl.move) begin
      rd_ph_r <= ins_r ? wrap_inc(rd_ph_r) : wrap_dec(rd_ph_r);
    end
    if (ctl.capture) begin
      data_r <= ram_rdata;
    end
    if (ctl.move) begin
      wp_addr_r <= ins_r ? wrap_dec(rd_ph_r) : wrap_inc(rd_ph_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      wp_r   <= 1'b0;
    end else begin
      wp_r <= ctl.move;
      if (ctl.decode) begin
        left_r <= dec_noop ? '0 : dec_moves;
      end else if (ctl.move) begin
        left_r <= left_r - CW'(1);
      end
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (!noop_r) begin
      case (cmd_r)
        fmbq_pkg::CMD_PUSH_FRONT, fmbq_pkg::CMD_PUSH_MIDDLE: begin
          head_nxt  = wrap_dec(head_r);
          count_nxt = count_r + CW'(1);
        end
        fmbq_pkg::CMD_PUSH_BACK: begin
          count_nxt = count_r + CW'(1);
        end
        fmbq_pkg::CMD_POP_FRONT, fmbq_pkg::CMD_POP_MIDDLE: begin
          head_nxt  = wrap_inc(head_r);
          count_nxt = count_r - CW'(1);
        end
        fmbq_pkg::CMD_POP_BACK: begin
          count_nxt = count_r - CW'(1);
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    res_data = '0;
    if (st_r == fmbq_pkg::ST_EMPTY) begin
      res_data = fmbq_pkg::EMPTY_DATA;
    end else if (is_pop && !noop_r) begin
      res_data = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_status_r <= st_r;
      out_data_r   <= res_data;
      out_occ_r    <= fmbq_pkg::OCC_W'(count_nxt);
    end
  end

  assign ram_re    = ctl.issue || ctl.move;
  assign ram_raddr = ctl.move ? rd_ph_r : tgt_r;
  assign ram_we    = wp_r || (ctl.commit && is_push && !noop_r);
  assign ram_waddr = wp_r ? wp_addr_r : tgt_r;
  assign ram_wdata = wp_r ? ram_rdata : value_r;

  fmbq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.noop      = noop_r;
  assign sts.pop       = is_pop && !noop_r;
  assign sts.has_moves = (left_r != '0);
  assign sts.last_move = (left_r == CW'(1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_occ_r, out_data_r, out_status_r};

endmodule

`default_nettype wire

### rtl/fmbq_ctrl.sv
// ---------------------------------------------------------------------------
// fmbq_ctrl
// Command sequencer of the queue: decode, read, entry moves and commit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire fmbq_pkg::sts_t sts,
  output fmbq_pkg::ctl_t      ctl
);

  fmbq_pkg::state_t state_r;
  fmbq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmbq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      fmbq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.latch = 1'b1;
          state_nxt = fmbq_pkg::S_DECODE;
        end
      end
      fmbq_pkg::S_DECODE: begin
        ctl.decode = 1'b1;
        state_nxt  = fmbq_pkg::S_ISSUE;
      end
      fmbq_pkg::S_ISSUE: begin
        ctl.issue = 1'b1;
        if (sts.noop) begin
          state_nxt = fmbq_pkg::S_COMMIT;
        end else if (sts.pop) begin
          state_nxt = fmbq_pkg::S_CAPTURE;
        end else if (sts.has_moves) begin
          state_nxt = fmbq_pkg::S_MOVE;
        end else begin
          state_nxt = fmbq_pkg::S_COMMIT;
        end
      end
      fmbq_pkg::S_CAPTURE: begin
        ctl.capture = 1'b1;
        state_nxt   = sts.has_moves ? fmbq_pkg::S_MOVE : fmbq_pkg::S_COMMIT;
      end
      fmbq_pkg::S_MOVE: begin
        ctl.move = 1'b1;
        if (sts.last_move) begin
          state_nxt = fmbq_pkg::S_DRAIN;
        end
      end
      fmbq_pkg::S_DRAIN: begin
        state_nxt = fmbq_pkg::S_COMMIT;
      end
      fmbq_pkg::S_COMMIT: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = fmbq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fmbq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/front_middle_back_queue.sv
// ---------------------------------------------------------------------------
// front_middle_back_queue
// Ordered queue of signed 32-bit values with push and pop at the front,
// the middle and the back, one result transaction per command.
//
// Channel  Dir  Payload (from bit 0 up)
// in_      in   cmd[2:0], value[34:3], zero pad to 40 bits
// out_     out  status[1:0], data[33:2], occupancy[44:34], zero pad to 48 bits
//
// Each command passes decode and issue before its commit, pops add a capture
// step, and commands that leave the queue unchanged go straight to commit.
// A middle push moves floor(n/2) entries and a middle pop floor((n-1)/2) for
// a queue of n entries, one entry per cycle through the single RAM port pair,
// plus a drain state when any entry moves.
// Entries sit in a circular buffer, so reset clears head and count but not the entries.
// A finished result waits in the output register while the next
// transaction is taken, and only its commit stalls on a held result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "front_middle_back_queue_assert.svh"

module front_middle_back_queue #(
  parameter int DEPTH = fmbq_pkg::DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // cmd[2:0], value[34:3]
  input  wire logic [fmbq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[1:0], data[33:2], occupancy[44:34]
  output logic      [fmbq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  fmbq_pkg::ctl_t ctl;
  fmbq_pkg::sts_t sts;

  fmbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fmbq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  `FMBQ_ASSERT(a_commit_free, clk, rst_n, ctl.commit |-> (!out_tvalid || out_tready), "held result")
  `FMBQ_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "busy accept")
  `FMBQ_ASSERT(a_result_from_commit, clk, rst_n, $rose(out_tvalid) |-> $past(ctl.commit), "no commit")
  `FMBQ_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// Testbench for front_middle_back_queue
// Sends push and pop commands at the front, middle and back of the queue and
// checks every result transaction against a queue image kept in the bench.
// The run covers empty pops, spare command codes, extreme values and random
// traffic, with random gaps on the input side and random back-pressure on
// the output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fmbq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int N_RANDOM    = 480;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int CALM_FROM   = 2000;
  localparam int CALM_TO     = 4000;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    bit                drain_first;
  } command_t;

  typedef struct packed {
    int                seq;
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  command_t          cmd_plan[$];
  outcome_t          outcomes_due[$];
  logic [DATA_W-1:0] queue_image[$];

  int     plan_count   = 0;
  int     accepted_cnt = 0;
  int     errors       = 0;
  longint cycles       = 0;
  bit     in_took      = 1'b0;
  logic   calm;

  assign calm = (cycles >= CALM_FROM) && (cycles < CALM_TO);

  always #1 clk = ~clk;

  front_middle_back_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic outcome_t apply_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
    outcome_t r;
    int       n;
    n = queue_image.size();
    r.seq = 0;
    r.status = ST_OK;
    r.data = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          queue_image.push_front(value);
        end else if (cmd == CMD_PUSH_MIDDLE) begin
          queue_image.insert(n / 2, value);
        end else begin
          queue_image.push_back(value);
        end
      end
      CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
          r.data = EMPTY_DATA;
        end else if (cmd == CMD_POP_FRONT) begin
          r.data = queue_image.pop_front();
        end else if (cmd == CMD_POP_MIDDLE) begin
          r.data = queue_image[(n - 1) / 2];
          queue_image.delete((n - 1) / 2);
        end else begin
          r.data = queue_image.pop_back();
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(queue_image.size());
    return r;
  endfunction

  task automatic plan(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value, bit drain_first = 1'b0);
    command_t c;
    c.cmd = cmd;
    c.value = value;
    c.drain_first = drain_first;
    cmd_plan.push_back(c);
    if (cmd <= CMD_PUSH_BACK) begin
      if (plan_count < DEPTH) plan_count++;
    end else if (cmd <= CMD_POP_BACK) begin
      if (plan_count > 0) plan_count--;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    outcome_t want;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction %h", out_tdata));
      end else begin
        want = outcomes_due.pop_front();
        if (out_tdata[ST_W-1:0] !== want.status)
          report_mismatch($sformatf("command %0d status %0d, expected %0d",
                                    want.seq, out_tdata[ST_W-1:0], want.status));
        if (out_tdata[ST_W +: DATA_W] !== want.data)
          report_mismatch($sformatf("command %0d data %h, expected %h",
                                    want.seq, out_tdata[ST_W +: DATA_W], want.data));
        if (out_tdata[ST_W+DATA_W +: OCC_W] !== want.occ)
          report_mismatch($sformatf("command %0d occupancy %0d, expected %0d",
                                    want.seq, out_tdata[ST_W+DATA_W +: OCC_W], want.occ));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      want = apply_command(in_tdata[CMD_W-1:0], in_tdata[CMD_W +: DATA_W]);
      want.seq = accepted_cnt;
      accepted_cnt++;
      outcomes_due.push_back(want);
    end
  end

  always @(negedge clk) begin : drive_in
    command_t nxt;
    bit       go;
    if (rst_n && (!in_tvalid || in_took)) begin
      go = (cmd_plan.size() != 0);
      if (go && cmd_plan[0].drain_first && outcomes_due.size() != 0) go = 1'b0;
      if (go && !calm && $urandom_range(99) < 36) go = 1'b0;
      if (go) begin
        nxt = cmd_plan.pop_front();
        in_tdata <= {{(IN_TDATA_W-CMD_W-DATA_W){1'b0}}, nxt.value, nxt.cmd};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 36);
  end

  initial begin : stimulus
    int               done;
    logic [CMD_W-1:0] c;

    plan(CMD_POP_FRONT, $urandom);
    plan(CMD_POP_MIDDLE, $urandom);
    plan(CMD_POP_BACK, $urandom);
    plan(CMD_SPARE_6, $urandom);
    plan(CMD_SPARE_7, $urandom);
    plan(CMD_PUSH_BACK, 32'h7fff_ffff);
    plan(CMD_PUSH_FRONT, 32'h8000_0000);
    plan(CMD_PUSH_MIDDLE, 32'h0000_0000);
    plan(CMD_PUSH_MIDDLE, 32'hffff_ffff);
    plan(CMD_PUSH_BACK, 32'h0000_0001);
    plan(CMD_PUSH_MIDDLE, 32'h5555_5555);
    plan(CMD_PUSH_FRONT, 32'haaaa_aaaa);
    plan(CMD_POP_MIDDLE, $urandom);
    plan(CMD_POP_MIDDLE, $urandom);
    plan(CMD_POP_FRONT, $urandom);
    plan(CMD_POP_BACK, $urandom);
    plan(CMD_POP_MIDDLE, $urandom);
    plan(CMD_POP_MIDDLE, $urandom);
    plan(CMD_POP_FRONT, $urandom);
    plan(CMD_POP_MIDDLE, $urandom);

    done = 0;
    while (done < N_RANDOM) begin
      if ($urandom_range(99) < 4) begin
        plan($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, $urandom);
      end else begin
        if ($urandom_range(99) < (plan_count < 40 ? 58 : 38))
          c = CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT));
        else
          c = CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT));
        plan(c, $urandom, (done == 0) || ($urandom_range(59) == 0));
        done++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (cmd_plan.size() != 0 || in_tvalid) @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/fmbq_pkg.sv
rtl/fmbq_ram.sv
rtl/fmbq_dpath.sv
rtl/fmbq_ctrl.sv
rtl/front_middle_back_queue.sv
dv/tb.sv
